// ----- rtl/core/csw_pkg.sv -----
`timescale 1ns / 1ps

package csw_pkg;

   // Operation codes carried in the request tuser field.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_KEY    = 2'd1,
      OP_SWITCH = 2'd2
   } csw_op_type;

   // Register index of ticks_per_second (register address bit 2).
   localparam logic CSW_REG_TICKS_PER_SECOND = 1'b0;

   // Reset value of ticks_per_second.
   localparam logic [15:0] CSW_TICKS_RESET = 16'd1000;

   // Wrap limits of the time units.
   localparam logic [5:0] CSW_MAX_SIXTY = 6'd59;
   localparam logic [5:0] CSW_MAX_HOUR  = 6'd23;

   // Key edge bit positions.
   localparam int unsigned KEY_RESET  = 0;
   localparam int unsigned KEY_UP     = 1;
   localparam int unsigned KEY_DOWN   = 2;
   localparam int unsigned KEY_SELECT = 3;

   // Switch edge bit positions.
   localparam int unsigned SW_VIEW   = 0;
   localparam int unsigned SW_ADJUST = 1;

   // One request transaction.
   typedef struct packed {
      csw_op_type op;
      logic [3:0] keys;
      logic [1:0] switches;
   } csw_item_type;

   // One response transaction.
   typedef struct packed {
      logic [31:0] display_word;
      logic        display_updated;
      logic        reset_request;
   } csw_result_type;

   // Segment pattern of one decimal digit; codes above nine show a zero.
   function automatic logic [7:0] seg_digit(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7C;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h67;
         default: seg = 8'h3F;
      endcase
      return seg;
   endfunction

   // Two digit bytes for a value below 64: tens in the upper byte.
   function automatic logic [15:0] seg_pair(input logic [5:0] value);
      logic [2:0] tens;
      logic [5:0] ones;
      if (value >= 6'd60)      tens = 3'd6;
      else if (value >= 6'd50) tens = 3'd5;
      else if (value >= 6'd40) tens = 3'd4;
      else if (value >= 6'd30) tens = 3'd3;
      else if (value >= 6'd20) tens = 3'd2;
      else if (value >= 6'd10) tens = 3'd1;
      else                     tens = 3'd0;
      ones = value - ({3'b000, tens} * 6'd10);
      return {seg_digit({1'b0, tens}), seg_digit(ones[3:0])};
   endfunction

   // Display word: left pair in the upper half, right pair in the lower.
   function automatic logic [31:0] build_word(input logic [5:0] left, input logic [5:0] right);
      return {seg_pair(left), seg_pair(right)};
   endfunction

   // Increment with wrap to zero above the limit.
   function automatic logic [5:0] wrap_inc(input logic [5:0] value, input logic [5:0] limit);
      return (value >= limit) ? 6'd0 : value + 6'd1;
   endfunction

   // Decrement with wrap to the limit below zero.
   function automatic logic [5:0] wrap_dec(input logic [5:0] value, input logic [5:0] limit);
      return (value == 6'd0 || value > limit) ? limit : value - 6'd1;
   endfunction

endpackage

// ----- rtl/core/csw_csr.sv -----
`timescale 1ns / 1ps

module csw_csr
   import csw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] ticks_per_second
);

   logic [15:0] tps_ff;
   logic [15:0] tps_in;
   logic        wr_en;

   // A write completes in the access phase; the port never stalls.
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      tps_in = tps_ff;
      if (wr_en && csr_paddr[2] == CSW_REG_TICKS_PER_SECOND) begin
         tps_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= CSW_TICKS_RESET;
      end else begin
         tps_ff <= tps_in;
      end
   end

   // Read decode; addresses past the register list read as zero.
   always_comb begin
      unique case (csr_paddr[2])
         CSW_REG_TICKS_PER_SECOND: csr_prdata = {16'h0000, tps_ff};
         default:                  csr_prdata = 32'h0000_0000;
      endcase
   end

   assign ticks_per_second = tps_ff;

endmodule

// ----- rtl/core/csw_core.sv -----
`timescale 1ns / 1ps

module csw_core
   import csw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  csw_item_type   item,
   input  logic [15:0]    ticks_per_second,
   output csw_result_type result
);

   logic [15:0] tick_count_ff,    tick_count_in;
   logic [5:0]  clock_seconds_ff, clock_seconds_in;
   logic [5:0]  clock_minutes_ff, clock_minutes_in;
   logic [4:0]  clock_hours_ff,   clock_hours_in;
   logic [5:0]  watch_seconds_ff, watch_seconds_in;
   logic [5:0]  watch_minutes_ff, watch_minutes_in;
   logic        show_clock_ff,    show_clock_in;
   logic        adjust_mode_ff,   adjust_mode_in;
   logic        watch_running_ff, watch_running_in;
   logic        hours_sel_ff,     hours_sel_in;
   logic [31:0] shown_word_ff,    shown_word_in;

   logic [16:0] tick_next;
   logic [5:0]  hours_next;
   logic [5:0]  unit_cur;
   logic [5:0]  unit_up;
   logic [5:0]  unit_adj;
   logic        updated;
   logic        reset_req;

   // Next state of the clock, stopwatch and mode flags for one transaction.
   always_comb begin
      tick_count_in    = tick_count_ff;
      clock_seconds_in = clock_seconds_ff;
      clock_minutes_in = clock_minutes_ff;
      clock_hours_in   = clock_hours_ff;
      watch_seconds_in = watch_seconds_ff;
      watch_minutes_in = watch_minutes_ff;
      show_clock_in    = show_clock_ff;
      adjust_mode_in   = adjust_mode_ff;
      watch_running_in = watch_running_ff;
      hours_sel_in     = hours_sel_ff;
      shown_word_in    = shown_word_ff;
      updated          = 1'b0;
      reset_req        = 1'b0;
      tick_next        = {1'b0, tick_count_ff} + 17'd1;
      hours_next       = wrap_inc({1'b0, clock_hours_ff}, CSW_MAX_HOUR);
      unit_cur         = '0;
      unit_up          = '0;
      unit_adj         = '0;

      case (item.op)
         OP_TICK: begin
            if (tick_next >= {1'b0, ticks_per_second}) begin
               // Full second: advance the clock, then the stopwatch if running.
               tick_count_in = 16'd0;
               updated       = 1'b1;
               if (clock_seconds_ff >= CSW_MAX_SIXTY) begin
                  clock_seconds_in = 6'd0;
                  if (clock_minutes_ff >= CSW_MAX_SIXTY) begin
                     clock_minutes_in = 6'd0;
                     clock_hours_in   = hours_next[4:0];
                  end else begin
                     clock_minutes_in = clock_minutes_ff + 6'd1;
                  end
               end else begin
                  clock_seconds_in = clock_seconds_ff + 6'd1;
               end
               if (watch_running_ff) begin
                  if (watch_seconds_ff >= CSW_MAX_SIXTY) begin
                     watch_seconds_in = 6'd0;
                     watch_minutes_in = wrap_inc(watch_minutes_ff, CSW_MAX_SIXTY);
                  end else begin
                     watch_seconds_in = watch_seconds_ff + 6'd1;
                  end
               end
               if (show_clock_ff) begin
                  shown_word_in = build_word({1'b0, clock_hours_in}, clock_minutes_in);
               end else begin
                  shown_word_in = build_word(watch_minutes_in, watch_seconds_in);
               end
            end else begin
               tick_count_in = tick_next[15:0];
            end
         end
         OP_KEY: begin
            if (item.keys[KEY_RESET]) begin
               reset_req = 1'b1;
            end else if (adjust_mode_ff && show_clock_ff) begin
               // Select toggles first, then up and down act on the selected unit.
               hours_sel_in = hours_sel_ff ^ item.keys[KEY_SELECT];
               if (hours_sel_in) begin
                  unit_cur = {1'b0, clock_hours_ff};
                  unit_up  = item.keys[KEY_UP] ? wrap_inc(unit_cur, CSW_MAX_HOUR) : unit_cur;
                  unit_adj = item.keys[KEY_DOWN] ? wrap_dec(unit_up, CSW_MAX_HOUR) : unit_up;
                  clock_hours_in = unit_adj[4:0];
               end else begin
                  unit_cur = clock_minutes_ff;
                  unit_up  = item.keys[KEY_UP] ? wrap_inc(unit_cur, CSW_MAX_SIXTY) : unit_cur;
                  unit_adj = item.keys[KEY_DOWN] ? wrap_dec(unit_up, CSW_MAX_SIXTY) : unit_up;
                  clock_minutes_in = unit_adj;
               end
            end else if (!show_clock_ff) begin
               // Stopwatch keys: start over pause over stop-and-clear.
               if (item.keys[KEY_UP]) begin
                  watch_running_in = 1'b1;
               end else if (item.keys[KEY_DOWN]) begin
                  watch_running_in = 1'b0;
               end else if (item.keys[KEY_SELECT]) begin
                  watch_running_in = 1'b0;
                  watch_seconds_in = 6'd0;
                  watch_minutes_in = 6'd0;
               end
            end
         end
         OP_SWITCH: begin
            if (item.switches[SW_VIEW]) begin
               show_clock_in = ~show_clock_ff;
            end else if (item.switches[SW_ADJUST]) begin
               adjust_mode_in = ~adjust_mode_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // State registers advance once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff    <= 16'd0;
         clock_seconds_ff <= 6'd0;
         clock_minutes_ff <= 6'd0;
         clock_hours_ff   <= 5'd0;
         watch_seconds_ff <= 6'd0;
         watch_minutes_ff <= 6'd0;
         show_clock_ff    <= 1'b1;
         adjust_mode_ff   <= 1'b0;
         watch_running_ff <= 1'b0;
         hours_sel_ff     <= 1'b1;
         shown_word_ff    <= 32'h0000_0000;
      end else if (fire) begin
         tick_count_ff    <= tick_count_in;
         clock_seconds_ff <= clock_seconds_in;
         clock_minutes_ff <= clock_minutes_in;
         clock_hours_ff   <= clock_hours_in;
         watch_seconds_ff <= watch_seconds_in;
         watch_minutes_ff <= watch_minutes_in;
         show_clock_ff    <= show_clock_in;
         adjust_mode_ff   <= adjust_mode_in;
         watch_running_ff <= watch_running_in;
         hours_sel_ff     <= hours_sel_in;
         shown_word_ff    <= shown_word_in;
      end
   end

   assign result.display_word    = shown_word_in;
   assign result.display_updated = updated;
   assign result.reset_request   = reset_req;

endmodule

// ----- rtl/core/clock_stopwatch_seven_segment.sv -----
`timescale 1ns / 1ps

// 24-hour clock with a minute:second stopwatch for a four-digit seven-segment
// display. Each request transaction (tick, key edges or switch edges) yields
// exactly one response transaction carrying the current display word. The
// block takes one transaction per clock cycle when not stalled; each passes
// through one input register, one pass of update logic and one result
// register. req_tready drops only when both registers are full and the
// response side stalls. ticks_per_second is written through the APB-style
// port at byte address 0 and should be changed only while the block is idle.
module clock_stopwatch_seven_segment
   import csw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] key_edges, [5:4] switch_edges, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] display_word
   output logic [1:0]  rsp_tuser,   // [0] display_updated, [1] reset_request
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic           in_valid_ff,  in_valid_in;
   csw_item_type   in_item_ff;
   logic           out_valid_ff, out_valid_in;
   csw_result_type out_result_ff;
   csw_result_type result;
   logic           advance;
   logic           fire;
   logic [15:0]    ticks_per_second;

   csw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .ticks_per_second (ticks_per_second)
   );

   csw_core u_core (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .item             (in_item_ff),
      .ticks_per_second (ticks_per_second),
      .result           (result)
   );

   // The pipeline moves when the result register is empty or being drained.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign fire       = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // Valid flags of the input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their own handshakes.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.op       <= csw_op_type'(req_tuser);
         in_item_ff.keys     <= req_tdata[3:0];
         in_item_ff.switches <= req_tdata[5:4];
      end
      if (fire) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_result_ff.display_word;
   assign rsp_tuser[0] = out_result_ff.display_updated;
   assign rsp_tuser[1] = out_result_ff.reset_request;

endmodule
